### src/fep_pkg.sv
// ----------------------------------------------------------------------------
// fep_pkg
// Shared types and constants for the fade envelope playhead channel.
// ----------------------------------------------------------------------------
package fep_pkg;

   // Field widths
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CLIP_W   = 16;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned FADE_W   = 24;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned PROD_W   = TIME_W + FADE_W;

   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [WEIGHT_W-1:0] ONE_Q15      = 16'h8000;
   localparam logic [WEIGHT_W-1:0] ZERO_Q15     = 16'h0000;
   localparam logic [FADE_W-1:0]   FADE_INSTANT = 24'hFF_FFFF;
   localparam logic [SPEED_W-1:0]  UNITY_SPEED  = 16'h0100;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_PLAY   = 3'd1,
      ACT_PAUSE  = 3'd2,
      ACT_STOP   = 3'd3,
      ACT_REWIND = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      MODE_NONE   = 3'd0,
      MODE_IN     = 3'd1,
      MODE_ACTIVE = 3'd2,
      MODE_OUT    = 3'd3,
      MODE_PAUSE  = 3'd4
   } mode_type;

   // multiplier operand selection
   typedef enum logic [1:0] {
      MUL_TV   = 2'd0,   // tick delta x global speed
      MUL_D1   = 2'd1,   // scaled delta x channel speed
      MUL_DT   = 2'd2,   // dt x fade speed
      MUL_HOLD = 2'd3    // keep the last product while the update waits
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        save_dt;
      logic        commit;
   } dp_cmd_type;

   typedef struct packed {
      logic req_is_tick;
   } dp_status_type;

endpackage

### src/fep_ctrl.sv
// ----------------------------------------------------------------------------
// fep_ctrl
// Sequencer: accepts a beat, steps the shared multiplier, commits the update
// and manages the result register handshake.
// ----------------------------------------------------------------------------
module fep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  fep_pkg::dp_status_type status,
   output fep_pkg::dp_cmd_type    cmd
);
   import fep_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL2 = 4'b0010,
      S_MUL3 = 4'b0100,
      S_UPD  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           accept;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.mul_sel = MUL_TV;
      cmd.save_dt = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = status.req_is_tick ? S_MUL2 : S_UPD;
            end
         end
         S_MUL2: begin
            cmd.mul_sel = MUL_D1;
            state_in    = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul_sel = MUL_DT;
            cmd.save_dt = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            // hold until the result register can take the new beat
            cmd.mul_sel = MUL_HOLD;
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/fep_datapath.sv
// ----------------------------------------------------------------------------
// fep_datapath
// Channel state, shared 32x24 multiplier with saturation, fade ramp and
// playhead update, and the result register.
// ----------------------------------------------------------------------------
module fep_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fep_pkg::SPEED_W-1:0]       csr_wr_data,
   input  logic [fep_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [2:0]                        req_tuser,
   output logic [fep_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  fep_pkg::dp_cmd_type               cmd,
   output fep_pkg::dp_status_type            status
);
   import fep_pkg::*;

   // configuration
   logic [SPEED_W-1:0]  global_speed_ff;

   // channel state
   mode_type            mode_ff, mode_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [TIME_W-1:0]   playhead_ff, playhead_in;
   logic [CLIP_W-1:0]   clip_ff, clip_in;
   logic [TIME_W-1:0]   length_ff, length_in;
   logic                loop_ff, loop_in;
   logic                end_pauses_ff, end_pauses_in;
   logic [FADE_W-1:0]   fade_speed_ff, fade_speed_in;
   logic [SPEED_W-1:0]  chan_speed_ff, chan_speed_in;

   // captured beat
   action_type          act_ff;
   logic [TIME_W-1:0]   tv_ff;
   logic [CLIP_W-1:0]   p_clip_ff;
   logic [TIME_W-1:0]   p_len_ff;
   logic                p_loop_ff;
   logic                p_pause_ff;
   logic [FADE_W-1:0]   p_fade_ff;
   logic [SPEED_W-1:0]  p_speed_ff;

   // multiplier
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TIME_W-1:0]   prod_sat;
   logic [TIME_W-1:0]   mul_a;
   logic [FADE_W-1:0]   mul_b;
   logic [TIME_W-1:0]   dt_ff;
   logic [WEIGHT_W-1:0] delta;

   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign status.req_is_tick = (action_type'(req_tuser) == ACT_TICK);

   // Q8.8 scale result: product >> 8, saturated to 32 bits
   assign prod_sat = (|prod_ff[PROD_W-1:40]) ? {TIME_W{1'b1}} : prod_ff[39:8];

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_TV: begin
            mul_a = req_tdata[31:0];
            mul_b = {8'd0, global_speed_ff};
         end
         MUL_D1: begin
            mul_a = prod_sat;
            mul_b = {8'd0, chan_speed_ff};
         end
         MUL_DT: begin
            mul_a = prod_sat;
            mul_b = fade_speed_ff;
         end
         MUL_HOLD: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      if (cmd.mul_sel == MUL_HOLD) begin
         prod_in = prod_ff;
      end else begin
         prod_in = {{FADE_W{1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};
      end
   end

   // weight step in Q1.15: (fade_speed * dt) >> 17, clamped to one
   always_comb begin
      if (fade_speed_ff == FADE_INSTANT && dt_ff != '0) begin
         delta = ONE_Q15;
      end else if (|prod_ff[PROD_W-1:32]) begin
         delta = ONE_Q15;
      end else begin
         delta = {1'b0, prod_ff[31:17]};
      end
   end

   always_comb begin
      logic [WEIGHT_W:0] w_sum;
      logic [TIME_W:0]   t_sum;
      logic [TIME_W-1:0] t_sat;
      mode_type          m;

      mode_in       = mode_ff;
      weight_in     = weight_ff;
      playhead_in   = playhead_ff;
      clip_in       = clip_ff;
      length_in     = length_ff;
      loop_in       = loop_ff;
      end_pauses_in = end_pauses_ff;
      fade_speed_in = fade_speed_ff;
      chan_speed_in = chan_speed_ff;
      w_sum         = {1'b0, weight_ff} + {1'b0, delta};
      t_sum         = '0;
      t_sat         = '0;
      m             = mode_ff;

      unique case (act_ff)
         ACT_TICK: begin
            if (clip_ff != '0) begin
               if (mode_ff == MODE_IN) begin
                  if (w_sum >= {1'b0, ONE_Q15}) begin
                     weight_in = ONE_Q15;
                     m         = MODE_ACTIVE;
                  end else begin
                     weight_in = w_sum[WEIGHT_W-1:0];
                  end
               end else if (mode_ff == MODE_OUT) begin
                  if (weight_ff <= delta) begin
                     weight_in = ZERO_Q15;
                     clip_in   = '0;
                     m         = MODE_NONE;
                  end else begin
                     weight_in = weight_ff - delta;
                  end
               end
               if (m != MODE_NONE && m != MODE_PAUSE) begin
                  t_sum = {1'b0, playhead_ff} + {1'b0, dt_ff};
                  t_sat = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
                  if (t_sat >= length_ff) begin
                     if (loop_ff) begin
                        playhead_in = t_sat - length_ff;
                     end else begin
                        playhead_in = length_ff;
                        m = end_pauses_ff ? MODE_PAUSE : MODE_OUT;
                     end
                  end else begin
                     playhead_in = t_sat;
                  end
               end
               mode_in = m;
            end
         end
         ACT_PLAY: begin
            if (p_clip_ff != '0) begin
               if (mode_ff != MODE_ACTIVE) begin
                  mode_in = MODE_IN;
               end
               if (clip_ff != p_clip_ff) begin
                  playhead_in = '0;
               end
               clip_in       = p_clip_ff;
               length_in     = p_len_ff;
               loop_in       = p_loop_ff;
               end_pauses_in = p_pause_ff;
               fade_speed_in = p_fade_ff;
               chan_speed_in = p_speed_ff;
            end
         end
         ACT_PAUSE: begin
            if (mode_ff != MODE_NONE) begin
               mode_in = MODE_PAUSE;
            end
         end
         ACT_STOP: begin
            if (mode_ff != MODE_NONE) begin
               mode_in = MODE_OUT;
            end
         end
         ACT_REWIND: begin
            if (clip_ff != '0) begin
               playhead_in = tv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_speed_ff <= UNITY_SPEED;
         mode_ff         <= MODE_NONE;
         weight_ff       <= ZERO_Q15;
         playhead_ff     <= '0;
         clip_ff         <= '0;
         length_ff       <= '0;
         loop_ff         <= 1'b0;
         end_pauses_ff   <= 1'b0;
         fade_speed_ff   <= '0;
         chan_speed_ff   <= UNITY_SPEED;
      end else begin
         if (csr_wr_en) begin
            global_speed_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            mode_ff       <= mode_in;
            weight_ff     <= weight_in;
            playhead_ff   <= playhead_in;
            clip_ff       <= clip_in;
            length_ff     <= length_in;
            loop_ff       <= loop_in;
            end_pauses_ff <= end_pauses_in;
            fade_speed_ff <= fade_speed_in;
            chan_speed_ff <= chan_speed_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.capture) begin
         act_ff     <= action_type'(req_tuser);
         tv_ff      <= req_tdata[31:0];
         p_clip_ff  <= req_tdata[47:32];
         p_len_ff   <= req_tdata[79:48];
         p_loop_ff  <= req_tdata[80];
         p_pause_ff <= req_tdata[81];
         p_fade_ff  <= req_tdata[105:82];
         p_speed_ff <= req_tdata[121:106];
      end
      if (cmd.save_dt) begin
         dt_ff <= prod_sat;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {5'd0, clip_in, playhead_in, weight_in, mode_in};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

### src/fade_envelope_playhead_core.sv
// ----------------------------------------------------------------------------
// fade_envelope_playhead_core
// One clip playback channel with fade in / fade out envelope and playhead.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one action per beat (tuser = action code: tick, play,
//   pause, stop, rewind). Every accepted beat returns exactly one rsp beat
//   with the channel status after that action.
//   csr_wr_en/csr_wr_data set the global Q8.8 speed; write only while idle.
// Sequence:
//   A tick's delta goes through one shared 32x24 multiplier for global speed,
//   channel speed and fade rate, one product per cycle, then the state
//   updates. Other actions go straight to the update. req_tready returns in
//   the cycle the result becomes valid; no new beat is accepted before then.
// Reset:
//   Synchronous, active high: none, weight 0, no clip, unity speeds, no result.
// Stall:
//   The result sits in a register until taken; the update step waits while
//   that register is full and not being read; req_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module fade_envelope_playhead_core (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,     // global_speed
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_value[31:0], clip_id[47:32], clip_length[79:48], loop_flag[80],
   // pause_at_end[81], fade_rate[105:82], speed_mult[121:106], zero fill
   input  logic [127:0] req_tdata,
   input  logic [2:0]   req_tuser,       // action[2:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // state_code[2:0], weight[18:3], play_time[50:19], current_clip[66:51],
   // zero fill
   output logic [71:0]  rsp_tdata
);
   import fep_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fep_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
